FILE: rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Clocked property checks for the RTL files; empty with NO_ASSERTIONS.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/skt_pkg.sv
// ============================================================================
// skt_pkg
// Types, codes and helpers for the sorted key table with grade histogram.
// ============================================================================
package skt_pkg;

    localparam int KEY_W    = 27;
    localparam int GRADE_W  = 7;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 7;
    localparam int BIN_W    = 4;
    localparam int NUM_BINS = 10;

    localparam logic [BIN_W-1:0] TOP_BIN = 4'd9;
    localparam logic [BIN_W-1:0] NO_BIN  = 4'd10;
    localparam logic [GRADE_W-1:0] GRADE_TOP = 7'd100;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [KEY_W-1:0]   key;
        logic               has_grade;
        logic [GRADE_W-1:0] grade_tenths;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    entry_count;
        logic [BIN_W-1:0]    bin_touched;
        logic [CNT_W-1:0]    bin_count;
    } t_out;

    // stored record, bit 0..26 key, 27 has_grade, 28..34 grade
    typedef struct packed {
        logic [GRADE_W-1:0] grade_tenths;
        logic               has_grade;
        logic [KEY_W-1:0]   key;
    } t_entry;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cap;   // latch compare flags against the incoming key
        logic ins;   // apply insert shift
        logic del;   // apply delete shift
    } t_cell_ctl;

    // histogram bin of a grade in tenths; 10.0 and above go to the top bin
    function automatic logic [BIN_W-1:0] bin_of(input logic [GRADE_W-1:0] g);
        logic [BIN_W-1:0] b;
        b = '0;
        if (g >= GRADE_TOP) begin
            b = TOP_BIN;
        end else begin
            for (int i = 1; i < NUM_BINS; i++) begin
                if (g >= GRADE_W'(i * 10)) begin
                    b = BIN_W'(i);
                end
            end
        end
        return b;
    endfunction

endpackage

FILE: rtl/skt_cell.sv
// ============================================================================
// skt_cell
// One slot of the sorted table: compares its key, shifts with its neighbors.
// ============================================================================
module skt_cell
    import skt_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int OCC_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [OCC_W-1:0] i_occ,
    input  logic [KEY_W-1:0] i_key,
    input  t_entry           i_new,
    input  t_entry           i_prev_entry,
    input  logic             i_prev_ge,
    input  logic             i_prev_valid,
    input  t_entry           i_next_entry,
    input  logic             i_next_valid,
    output t_entry           o_entry,
    output logic             o_ge,
    output logic             o_valid,
    output logic             o_eq,
    output t_entry           o_sel
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_ge;
    logic   r_eq;
    logic   w_valid;
    logic   w_at_end;

    assign w_valid  = OCC_W'(IDX) < i_occ;
    assign w_at_end = i_prev_valid && !w_valid;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_prev_ge) begin
                n_entry = i_prev_entry;
            end else if (r_ge || w_at_end) begin
                n_entry = i_new;
            end
        end else if (i_ctl.del && r_ge) begin
            // pull the upper neighbor down, clear the freed top slot
            n_entry = i_next_valid ? i_next_entry : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ge <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cap) begin
            r_ge <= w_valid && (r_entry.key >= i_key);
            r_eq <= w_valid && (r_entry.key == i_key);
        end
    end

    assign o_entry = r_entry;
    assign o_ge    = r_ge;
    assign o_valid = w_valid;
    assign o_eq    = r_eq;
    assign o_sel   = r_eq ? r_entry : '0;

endmodule

FILE: rtl/sorted_key_table_with_histogram_top.sv
// ============================================================================
// sorted_key_table_with_histogram_top
// Sorted table of unique keys held in a chain of cells, with grade histogram.
// ============================================================================
//
//  channel   handshake          payload
//  --------  -----------------  -----------------------------------------
//  command   start / busy       i_in  : kind, key, has_grade, grade_tenths
//  result    o_valid (strobe)   o_res : status, entry_count, bin_touched,
//                                       bin_count
//
//  At the accept edge every cell compares its key against the incoming
//  one; in the apply state all cells shift in parallel and
//  the histogram updates. The result strobe follows for one cycle, and
//  busy is already low then, so the next item is taken in that cycle.
//  Reset clears occupancy, histogram and control; table slots are not cleared.
//  The receiver cannot stall; each result is shown for exactly one cycle.
//
module sorted_key_table_with_histogram_top
    import skt_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_in,
    output logic busy,
    output logic o_valid,
    output t_out o_res
);

`include "assert_macros.svh"

    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_in               r_op;
    logic [OCC_W-1:0]  r_occ;
    logic [OCC_W-1:0]  n_occ;
    logic [OCC_W-1:0]  r_bins [NUM_BINS];
    logic [OCC_W-1:0]  n_bins [NUM_BINS];
    logic              r_valid;
    t_out              r_res;
    t_out              n_res;

    t_cell_ctl              w_ctl;
    t_entry                 w_new;
    t_entry                 w_ent      [MAX_ENTRIES+1:0];
    logic [MAX_ENTRIES:0]   w_ge_chain;
    logic [MAX_ENTRIES+1:0] w_valid_chain;
    logic [MAX_ENTRIES-1:0] w_eq;
    t_entry                 w_sel      [MAX_ENTRIES];
    t_entry                 w_hit;
    logic                   w_accept;
    logic                   w_apply;
    logic                   w_any_eq;
    logic                   w_full;
    logic                   w_ins_ok;
    logic                   w_del_ok;
    logic                   w_hg;
    logic [BIN_W-1:0]       w_bin;
    logic [OCC_W-1:0]       w_bin_new;
    logic [OCC_W+CNT_W-1:0] w_occ_ext;
    logic [OCC_W+CNT_W-1:0] w_bin_ext;

    assign w_accept = start && !busy;
    assign w_apply  = (r_state == S_APPLY);
    assign busy     = w_apply;

    assign w_new = '{grade_tenths: r_op.grade_tenths,
                     has_grade:    r_op.has_grade,
                     key:          r_op.key};

    assign w_ctl.cap = w_accept;
    assign w_ctl.ins = w_apply && w_ins_ok;
    assign w_ctl.del = w_apply && w_del_ok;

    assign w_ent[0]                    = '0;
    assign w_ent[MAX_ENTRIES+1]        = '0;
    assign w_ge_chain[0]               = 1'b0;
    assign w_valid_chain[0]            = 1'b1;
    assign w_valid_chain[MAX_ENTRIES+1] = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        skt_cell #(
            .IDX   (g),
            .OCC_W (OCC_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_occ        (r_occ),
            .i_key        (i_in.key),
            .i_new        (w_new),
            .i_prev_entry (w_ent[g]),
            .i_prev_ge    (w_ge_chain[g]),
            .i_prev_valid (w_valid_chain[g]),
            .i_next_entry (w_ent[g+2]),
            .i_next_valid (w_valid_chain[g+2]),
            .o_entry      (w_ent[g+1]),
            .o_ge         (w_ge_chain[g+1]),
            .o_valid      (w_valid_chain[g+1]),
            .o_eq         (w_eq[g]),
            .o_sel        (w_sel[g])
        );
    end

    // matching record, at most one cell hits since keys are unique
    always_comb begin
        w_hit = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_hit = w_hit | w_sel[i];
        end
    end

    assign w_any_eq = |w_eq;
    assign w_full   = r_occ >= OCC_W'(MAX_ENTRIES);
    assign w_ins_ok = (r_op.kind == KIND_INSERT) && !w_full && !w_any_eq;
    assign w_del_ok = (r_op.kind == KIND_DELETE) && w_any_eq;
    assign w_hg     = (r_op.kind == KIND_DELETE) ? w_hit.has_grade : r_op.has_grade;
    assign w_bin    = bin_of((r_op.kind == KIND_DELETE) ? w_hit.grade_tenths
                                                        : r_op.grade_tenths);

    always_comb begin
        if (r_op.kind == KIND_INSERT) begin
            w_bin_new = r_bins[w_bin] + 1'b1;
        end else if (r_bins[w_bin] == '0) begin
            w_bin_new = '0;   // saturate at zero
        end else begin
            w_bin_new = r_bins[w_bin] - 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_bins  = r_bins;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state           = S_IDLE;
                n_res.bin_touched = NO_BIN;
                n_res.bin_count   = '0;
                if (r_op.kind == KIND_INSERT) begin
                    if (w_full) begin
                        n_res.status = ST_FULL;
                    end else if (w_any_eq) begin
                        n_res.status = ST_DUPLICATE;
                    end else begin
                        n_res.status = ST_INSERTED;
                        n_occ        = r_occ + 1'b1;
                    end
                end else begin
                    if (w_any_eq) begin
                        n_res.status = ST_DELETED;
                        n_occ        = r_occ - 1'b1;
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end
                if ((w_ins_ok || w_del_ok) && w_hg) begin
                    n_bins[w_bin]     = w_bin_new;
                    n_res.bin_touched = w_bin;
                    n_res.bin_count   = w_bin_ext[CNT_W-1:0];
                end
                n_res.entry_count = w_occ_ext[CNT_W-1:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_occ_ext = {{CNT_W{1'b0}}, n_occ};
    assign w_bin_ext = {{CNT_W{1'b0}}, w_bin_new};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++) begin
                r_bins[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_valid <= w_apply;
            r_bins  <= n_bins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    `ASSERT_CLK(a_accept_then_apply, i_clk, i_rst_n, w_accept |=> w_apply)
    `ASSERT_CLK(a_apply_then_result, i_clk, i_rst_n, w_apply |=> r_valid)
    `ASSERT_CLK(a_single_hit, i_clk, i_rst_n, $onehot0(w_eq))
    `ASSERT_NEVER(a_occ_bound, i_clk, i_rst_n, r_occ > OCC_W'(MAX_ENTRIES))
    `ASSERT_CLK(a_insert_grows, i_clk, i_rst_n,
        (r_valid && (r_res.status == ST_INSERTED)) |-> (r_occ == $past(r_occ) + 1'b1))

endmodule
